// ===== hdl/stt_pkg.sv =====
// Package for the source text tokenizer: token kinds, scanner modes,
// character codes, keyword tables and the result record type.
// No dependencies.
package stt_pkg;

    localparam int OUT_W    = 16;  // width of token_start / token_length
    localparam int KIND_W   = 5;
    localparam int MODE_W   = 3;
    localparam int KW_COUNT = 9;
    localparam int KW_CHARS = 7;   // longest keyword plus padding

    // scanner modes
    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDENT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLOAT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EQ    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HALT  = 3'd5;

    // token kinds
    localparam logic [KIND_W-1:0] K_IDENT = 5'd0;
    localparam logic [KIND_W-1:0] K_INT   = 5'd1;
    localparam logic [KIND_W-1:0] K_FLOAT = 5'd2;
    localparam logic [KIND_W-1:0] K_KW0   = 5'd3;
    localparam logic [KIND_W-1:0] K_LBRK  = 5'd12;
    localparam logic [KIND_W-1:0] K_RBRK  = 5'd13;
    localparam logic [KIND_W-1:0] K_LPAR  = 5'd14;
    localparam logic [KIND_W-1:0] K_RPAR  = 5'd15;
    localparam logic [KIND_W-1:0] K_LBRC  = 5'd16;
    localparam logic [KIND_W-1:0] K_RBRC  = 5'd17;
    localparam logic [KIND_W-1:0] K_COMMA = 5'd18;
    localparam logic [KIND_W-1:0] K_PLUS  = 5'd19;
    localparam logic [KIND_W-1:0] K_MINUS = 5'd20;
    localparam logic [KIND_W-1:0] K_STAR  = 5'd21;
    localparam logic [KIND_W-1:0] K_SLASH = 5'd22;
    localparam logic [KIND_W-1:0] K_EQ    = 5'd23;
    localparam logic [KIND_W-1:0] K_EQEQ  = 5'd24;
    localparam logic [KIND_W-1:0] K_BANG  = 5'd25;
    localparam logic [KIND_W-1:0] K_GT    = 5'd26;
    localparam logic [KIND_W-1:0] K_LT    = 5'd27;
    localparam logic [KIND_W-1:0] K_SEMI  = 5'd28;
    localparam logic [KIND_W-1:0] K_COLON = 5'd29;
    localparam logic [KIND_W-1:0] K_END   = 5'd30;
    localparam logic [KIND_W-1:0] K_ERR   = 5'd31;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_UNDER = 8'd95;

    localparam logic [KW_COUNT-1:0] ALL_KW = '1;

    // keyword spellings, zero padded, in kind order
    localparam logic [7:0] KW_CHAR [KW_COUNT][KW_CHARS] = '{
        '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "o", "n", "g", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd3, 3'd4, 3'd6, 3'd5, 3'd2, 3'd4, 3'd5, 3'd3
    };

    typedef struct packed {
        logic              last;
        logic [OUT_W-1:0]  length;
        logic [OUT_W-1:0]  start;
        logic [KIND_W-1:0] kind;
    } tok_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // single-character punctuation; K_IDENT means "not punctuation"
    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            "[":     k = K_LBRK;
            "]":     k = K_RBRK;
            "(":     k = K_LPAR;
            ")":     k = K_RPAR;
            "{":     k = K_LBRC;
            "}":     k = K_RBRC;
            ",":     k = K_COMMA;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "!":     k = K_BANG;
            ">":     k = K_GT;
            "<":     k = K_LT;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/source_text_tokenizer.sv =====
// Source text tokenizer top level: byte-stream scanner and a four-entry
// token queue feeding the result stream. Depends on stt_pkg.
// Latency: a token is offered on m_ in the cycle after the byte ending it is
// accepted, behind any tokens already queued.
// Throughput: one byte per cycle; a byte with two tokens gives two output
// transactions, and s_tready drops while three or more tokens are queued.
module source_text_tokenizer #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,   // synchronous, active low: idle at offset zero
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    // token stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] token_kind, [20:5] token_start,
                                   // [36:21] token_length, [39:37] zero
    output logic        m_tlast    // run_last
);
    import stt_pkg::*;

    localparam int PB    = POSITION_BITS;
    localparam int WIDE  = POSITION_BITS + OUT_W;
    localparam int QD    = 4;   // token queue depth
    localparam logic [PB-1:0] POS_MAX = '1;

    // -------- scanner state --------
    logic [MODE_W-1:0]   mode_reg,  mode_next;
    logic [PB-1:0]       pos_reg,   pos_next;
    logic [PB-1:0]       pstart_reg, pstart_next;
    logic [PB-1:0]       plen_reg,  plen_next;
    logic [KW_COUNT-1:0] cand_reg,  cand_next;

    // -------- token queue --------
    tok_t       q_reg [QD];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    logic       s_fire, m_fire;
    logic [7:0] c;
    logic       em_a, em_b;     // pending token ended / this byte's own token
    tok_t       tok_a, tok_b, tok_first, tok_second;
    logic [1:0] push_n;

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    // saturate a position-width value to the 16-bit result field
    function automatic logic [OUT_W-1:0] to_out(input logic [PB-1:0] v);
        logic [WIDE-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        if (w > WIDE'({OUT_W{1'b1}})) begin
            return {OUT_W{1'b1}};
        end
        return w[OUT_W-1:0];
    endfunction

    // narrow the keyword candidate set by the character at offset idx
    function automatic logic [KW_COUNT-1:0] filter_kw(input logic [KW_COUNT-1:0] m,
                                                      input logic [PB-1:0] idx,
                                                      input logic [7:0] ch);
        logic [KW_COUNT-1:0] r;
        logic [2:0]          i3;
        r  = '0;
        i3 = idx[2:0];
        if (idx < PB'(KW_CHARS)) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                r[i] = m[i] && (i3 < KW_LEN[i]) && (KW_CHAR[i][i3] == ch);
            end
        end
        return r;
    endfunction

    // whole-word keyword match: first candidate whose length equals the word's
    function automatic logic [KIND_W-1:0] ident_kind(input logic [KW_COUNT-1:0] m,
                                                     input logic [PB-1:0] len);
        logic [KIND_W-1:0] k;
        logic              hit;
        k   = K_IDENT;
        hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!hit && m[i] && len == PB'(KW_LEN[i])) begin
                k   = K_KW0 + KIND_W'(i);
                hit = 1'b1;
            end
        end
        return k;
    endfunction

    assign c        = s_tdata;
    assign s_tready = (count_reg <= 3'd2);   // room for two tokens
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 3'd0);
    assign m_fire   = m_tvalid && m_tready;

    // -------- scanner: one byte per accepted transaction --------
    always_comb begin
        logic fall;
        fall        = 1'b0;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        cand_next   = cand_reg;
        em_a        = 1'b0;
        em_b        = 1'b0;
        tok_a       = '0;
        tok_b       = '0;
        tok_a.start = to_out(pstart_reg);

        unique case (mode_reg) inside
            MODE_HALT: begin
                // discard until end of text, which restarts silently
                if (c == CH_NUL) begin
                    mode_next   = MODE_IDLE;
                    pos_next    = '0;
                    pstart_next = '0;
                    plen_next   = '0;
                    cand_next   = ALL_KW;
                end
            end
            MODE_IDENT: begin
                if (is_letter(c)) begin
                    cand_next = filter_kw(cand_reg, plen_reg, c);
                    plen_next = sat_inc(plen_reg);
                    pos_next  = sat_inc(pos_reg);
                end else begin
                    em_a         = 1'b1;
                    tok_a.kind   = ident_kind(cand_reg, plen_reg);
                    tok_a.length = to_out(plen_reg);
                    fall         = 1'b1;
                end
            end
            MODE_INT, MODE_FLOAT: begin
                if (is_digit(c) || (c == CH_DOT && mode_reg == MODE_INT)) begin
                    if (c == CH_DOT) begin
                        mode_next = MODE_FLOAT;
                    end
                    plen_next = sat_inc(plen_reg);
                    pos_next  = sat_inc(pos_reg);
                end else begin
                    em_a         = 1'b1;
                    tok_a.kind   = (mode_reg == MODE_INT) ? K_INT : K_FLOAT;
                    tok_a.length = to_out(plen_reg);
                    fall         = 1'b1;
                end
            end
            MODE_EQ: begin
                em_a = 1'b1;
                if (c == CH_EQ) begin
                    tok_a.kind   = K_EQEQ;
                    tok_a.length = OUT_W'(2);
                    mode_next    = MODE_IDLE;
                    pos_next     = sat_inc(pos_reg);
                end else begin
                    tok_a.kind   = K_EQ;
                    tok_a.length = OUT_W'(1);
                    fall         = 1'b1;
                end
            end
            default: begin
                fall = 1'b1;
            end
        endcase

        // classify the byte itself from the between-token state
        if (fall) begin
            mode_next   = MODE_IDLE;
            tok_b.start = to_out(pos_reg);
            if (c == CH_NUL) begin
                em_b         = 1'b1;
                tok_b.kind   = K_END;
                tok_b.length = '0;
                pos_next     = '0;
                pstart_next  = '0;
                plen_next    = '0;
                cand_next    = ALL_KW;
            end else begin
                pos_next = sat_inc(pos_reg);
                if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
                    // whitespace skipped
                end else if (is_letter(c) || c == CH_UNDER) begin
                    mode_next   = MODE_IDENT;
                    pstart_next = pos_reg;
                    plen_next   = PB'(1);
                    cand_next   = filter_kw(ALL_KW, '0, c);
                end else if (is_digit(c)) begin
                    mode_next   = MODE_INT;
                    pstart_next = pos_reg;
                    plen_next   = PB'(1);
                end else if (c == CH_EQ) begin
                    mode_next   = MODE_EQ;
                    pstart_next = pos_reg;
                    plen_next   = PB'(1);
                end else if (punct_kind(c) != K_IDENT) begin
                    em_b         = 1'b1;
                    tok_b.kind   = punct_kind(c);
                    tok_b.length = OUT_W'(1);
                end else begin
                    em_b         = 1'b1;
                    tok_b.kind   = K_ERR;
                    tok_b.length = OUT_W'(1);
                    mode_next    = MODE_HALT;
                end
            end
        end

        push_n          = {1'b0, em_a} + {1'b0, em_b};
        tok_first       = em_a ? tok_a : tok_b;
        tok_first.last  = (push_n == 2'd1);
        tok_second      = tok_b;
        tok_second.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            cand_reg   <= ALL_KW;
        end else if (s_fire) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            cand_reg   <= cand_next;
        end
    end

    // -------- token queue --------
    always_ff @(posedge aclk) begin
        if (s_fire && push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= tok_first;
        end
        if (s_fire && push_n == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= tok_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_fire) begin
                wr_ptr_reg <= wr_ptr_reg + push_n;
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (s_fire ? {1'b0, push_n} : 3'd0)
                         - {2'b0, m_fire};
        end
    end

    assign m_tdata = {3'b000, q_reg[rd_ptr_reg].length, q_reg[rd_ptr_reg].start,
                      q_reg[rd_ptr_reg].kind};
    assign m_tlast = q_reg[rd_ptr_reg].last;

    // -------- assertions --------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(QD))
        else $error("token queue overfilled");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && mode_reg == MODE_HALT) |-> push_n == 2'd0)
        else $error("token produced while discarding after error");

    a_end_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && c == CH_NUL) |=> (pos_reg == '0 && mode_reg == MODE_IDLE))
        else $error("end of text did not restart scanner");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> (count_reg + {1'b0, push_n} <= 3'(QD)))
        else $error("byte accepted without room for its tokens");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for source_text_tokenizer: directed and random byte
// streams, a bit-accurate token predictor and a streaming scoreboard.
// Depends on stt_pkg and the source_text_tokenizer RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int unsigned POS_MAX      = (1 << OUT_W) - 1;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          TAIL_CYCLES  = 16;
    localparam int          CYCLE_LIMIT  = 1_000_000;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] text_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [4:0] kind, [20:5] start, [36:21] length
    logic        m_tlast;         // last token of the byte

    source_text_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Token predictor: own copy of the scanner state
    // ------------------------------------------------------------------
    string kw_word [KW_COUNT] = '{"fn", "int", "long", "return", "print",
                                  "if", "else", "while", "for"};
    string punct_chars = "[](){},+-*/!><;:";

    logic [MODE_W-1:0]   sc_mode;
    int unsigned         sc_pos;
    int unsigned         sc_start;
    int unsigned         sc_len;
    logic [KW_COUNT-1:0] sc_kw;

    tok_t tok_exp [$];            // tokens still owed by the DUT

    function automatic void scan_clear();
        sc_mode  = MODE_IDLE;
        sc_pos   = 0;
        sc_start = 0;
        sc_len   = 0;
        sc_kw    = ALL_KW;
    endfunction

    function automatic int unsigned sat_up(input int unsigned v);
        return (v >= POS_MAX) ? POS_MAX : v + 1;
    endfunction

    function automatic bit letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // K_IDENT here means the byte is not punctuation
    function automatic logic [KIND_W-1:0] punct_code(input logic [7:0] c);
        case (c)
            "[": return K_LBRK;
            "]": return K_RBRK;
            "(": return K_LPAR;
            ")": return K_RPAR;
            "{": return K_LBRC;
            "}": return K_RBRC;
            ",": return K_COMMA;
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            "/": return K_SLASH;
            "!": return K_BANG;
            ">": return K_GT;
            "<": return K_LT;
            ";": return K_SEMI;
            ":": return K_COLON;
            default: return K_IDENT;
        endcase
    endfunction

    // keep only keywords whose letter at position idx equals c
    function automatic logic [KW_COUNT-1:0] kw_narrow(input logic [KW_COUNT-1:0] mask,
                                                       input int unsigned idx,
                                                       input logic [7:0] c);
        logic [KW_COUNT-1:0] res;
        res = '0;
        for (int i = 0; i < KW_COUNT; i++)
            if (mask[i] && idx < kw_word[i].len() && kw_word[i][idx] == c)
                res[i] = 1'b1;
        return res;
    endfunction

    // whole-word match only: the surviving candidate must have this length
    function automatic logic [KIND_W-1:0] word_kind();
        for (int i = 0; i < KW_COUNT; i++)
            if (sc_kw[i] && sc_len == kw_word[i].len())
                return K_KW0 + KIND_W'(i);
        return K_IDENT;
    endfunction

    function automatic void note(input logic [KIND_W-1:0] kind,
                                 input int unsigned start, input int unsigned len);
        tok_t t;
        t.kind   = kind;
        t.start  = OUT_W'(start);
        t.length = OUT_W'(len);
        t.last   = 1'b0;
        tok_exp.push_back(t);
    endfunction

    // advance the scanner by one accepted byte, queueing owed tokens
    function automatic void scan_byte(input logic [7:0] c);
        int               n0;
        logic [KIND_W-1:0] pk;
        n0 = tok_exp.size();
        case (sc_mode) inside
            MODE_HALT: begin
                // after an error everything up to the terminator is dropped
                if (c == CH_NUL)
                    scan_clear();
                return;
            end
            MODE_IDENT: begin
                if (letter(c)) begin
                    sc_kw  = kw_narrow(sc_kw, sc_len, c);
                    sc_len = sat_up(sc_len);
                    sc_pos = sat_up(sc_pos);
                    return;
                end
                note(word_kind(), sc_start, sc_len);
            end
            MODE_INT, MODE_FLOAT: begin
                if (digit(c) || (c == CH_DOT && sc_mode == MODE_INT)) begin
                    if (c == CH_DOT)
                        sc_mode = MODE_FLOAT;
                    sc_len = sat_up(sc_len);
                    sc_pos = sat_up(sc_pos);
                    return;
                end
                note((sc_mode == MODE_INT) ? K_INT : K_FLOAT, sc_start, sc_len);
            end
            MODE_EQ: begin
                if (c == CH_EQ) begin
                    note(K_EQEQ, sc_start, 2);
                    tok_exp[tok_exp.size()-1].last = 1'b1;
                    sc_mode = MODE_IDLE;
                    sc_pos  = sat_up(sc_pos);
                    return;
                end
                note(K_EQ, sc_start, 1);
            end
            default: ;
        endcase
        sc_mode = MODE_IDLE;

        if (c == CH_NUL) begin
            note(K_END, sc_pos, 0);
            scan_clear();
        end else begin
            pk = punct_code(c);
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
                // whitespace only moves the offset
            end else if (letter(c) || c == CH_UNDER) begin
                sc_mode  = MODE_IDENT;
                sc_start = sc_pos;
                sc_len   = 1;
                sc_kw    = kw_narrow(ALL_KW, 0, c);
            end else if (digit(c)) begin
                sc_mode  = MODE_INT;
                sc_start = sc_pos;
                sc_len   = 1;
            end else if (c == CH_EQ) begin
                sc_mode  = MODE_EQ;
                sc_start = sc_pos;
                sc_len   = 1;
            end else if (pk != K_IDENT) begin
                note(pk, sc_pos, 1);
            end else begin
                note(K_ERR, sc_pos, 1);
                sc_mode = MODE_HALT;
            end
            sc_pos = sat_up(sc_pos);
        end

        if (tok_exp.size() > n0)
            tok_exp[tok_exp.size()-1].last = 1'b1;
    endfunction

    // replace the predicted final token of a byte with a hand-typed one
    function automatic void pin_last(input logic [KIND_W-1:0] kind,
                                     input int unsigned start, input int unsigned len);
        tok_exp[tok_exp.size()-1].kind   = kind;
        tok_exp[tok_exp.size()-1].start  = OUT_W'(start);
        tok_exp[tok_exp.size()-1].length = OUT_W'(len);
    endfunction

    // ------------------------------------------------------------------
    // Flow control shared between sender and receiver
    // ------------------------------------------------------------------
    bit calm          = 1'b0;     // no random idling on either side
    bit hold_off_req  = 1'b0;     // receiver: go quiet for HOLD_CYCLES
    int fail_count    = 0;
    int cycle_count   = 0;

    // offer one byte, predict once the transaction completes
    task automatic put_byte(input logic [7:0] ch);
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        scan_byte(ch);
    endtask

    // stop offering until every owed token has been seen
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (tok_exp.size() != 0);
    endtask

    function automatic logic [7:0] rand_letter();
        int k;
        k = $urandom_range(0, 51);
        return (k < 26) ? 8'("a" + k) : 8'("A" + k - 26);
    endfunction

    // one random text: mostly well-formed tokens, a little noise, then NUL
    task automatic send_text(inout int sent);
        logic [7:0] txt [$];
        int pick, n, w;
        repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                w = $urandom_range(0, KW_COUNT - 1);
                for (int k = 0; k < kw_word[w].len(); k++)
                    txt.push_back(kw_word[w][k]);
                // capitalised keyword is a plain identifier
                if ($urandom_range(0, 4) == 0)
                    txt[txt.size()-kw_word[w].len()] = kw_word[w][0] - 8'd32;
                // keyword as a prefix of a longer word
                if ($urandom_range(0, 4) == 0)
                    txt.push_back(rand_letter());
            end else if (pick < 36) begin
                txt.push_back(($urandom_range(0, 5) == 0) ? CH_UNDER : rand_letter());
                repeat ($urandom_range(0, 6))
                    txt.push_back(rand_letter());
            end else if (pick < 50) begin
                repeat ($urandom_range(1, 5))
                    txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end else if (pick < 60) begin
                repeat ($urandom_range(1, 3))
                    txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                txt.push_back(CH_DOT);
                repeat ($urandom_range(0, 3))
                    txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end else if (pick < 78) begin
                txt.push_back(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 3))
                    txt.push_back(CH_EQ);
            end else if (pick < 96) begin
                txt.push_back(8'($urandom_range(1, 255)));
            end else begin
                txt.push_back(CH_DOT);
            end
            // whitespace after some tokens; adjacent tokens give two results on one byte
            if ($urandom_range(0, 9) >= 4) begin
                n = $urandom_range(1, 2);
                repeat (n) begin
                    case ($urandom_range(0, 2))
                        0:       txt.push_back(CH_SPACE);
                        1:       txt.push_back(CH_TAB);
                        default: txt.push_back(CH_LF);
                    endcase
                end
            end
        end
        txt.push_back(CH_NUL);
        foreach (txt[i]) begin
            if (sc_mode != MODE_HALT)
                sent++;
            put_byte(txt[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table; typed rows pin the final token of that byte
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0]        ch;
        bit                typed;
        logic [KIND_W-1:0] kind;
        int unsigned       start;
        int unsigned       len;
    } step_t;

    step_t plan [25] = '{
        '{CH_NUL,   1'b1, K_END,   0, 0},  // empty text straight after reset
        '{"i",      1'b0, K_IDENT, 0, 0},
        '{"f",      1'b0, K_IDENT, 0, 0},
        '{"(",      1'b0, K_IDENT, 0, 0},  // keyword and bracket together
        '{CH_UNDER, 1'b0, K_IDENT, 0, 0},
        '{"a",      1'b0, K_IDENT, 0, 0},
        '{"1",      1'b0, K_IDENT, 0, 0},  // digit ends identifier
        '{CH_DOT,   1'b0, K_IDENT, 0, 0},
        '{"5",      1'b0, K_IDENT, 0, 0},
        '{CH_DOT,   1'b1, K_ERR,   8, 1},  // second dot: float then error
        '{"z",      1'b0, K_IDENT, 0, 0},  // discarded
        '{CH_NUL,   1'b0, K_IDENT, 0, 0},  // silent restart
        '{8'hFF,    1'b1, K_ERR,   0, 1},  // top byte value is unknown
        '{CH_NUL,   1'b0, K_IDENT, 0, 0},
        '{"e",      1'b0, K_IDENT, 0, 0},
        '{"l",      1'b0, K_IDENT, 0, 0},
        '{"s",      1'b0, K_IDENT, 0, 0},
        '{"e",      1'b0, K_IDENT, 0, 0},
        '{CH_EQ,    1'b0, K_IDENT, 0, 0},  // ends 'else', length four
        '{CH_EQ,    1'b0, K_IDENT, 0, 0},  // '=='
        '{CH_EQ,    1'b0, K_IDENT, 0, 0},
        '{CH_TAB,   1'b0, K_IDENT, 0, 0},  // lone '='
        '{"9",      1'b0, K_IDENT, 0, 0},
        '{CH_DOT,   1'b0, K_IDENT, 0, 0},
        '{CH_NUL,   1'b0, K_IDENT, 0, 0}   // float without fraction, then end
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int  sent;
        bit  hold_done;
        bit  drain_done;
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        scan_clear();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            put_byte(plan[i].ch);
            if (plan[i].typed)
                pin_last(plan[i].kind, plan[i].start, plan[i].len);
        end

        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 300 && sent < 500);
            // receiver goes quiet while bytes keep coming: queue fills up
            if (!hold_done && sent >= 150) begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && sent >= 700) begin
                drain();
                drain_done = 1'b1;
            end
            send_text(sent);
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("source_text_tokenizer: match");
        else
            $display("source_text_tokenizer: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    initial begin : receiver
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: each token transaction against the oldest owed token
    // ------------------------------------------------------------------
    initial begin : scoreboard
        tok_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (tok_exp.size() == 0) begin
                    $error("unexpected token: kind %0d start %0d length %0d",
                           m_tdata[4:0], m_tdata[20:5], m_tdata[36:21]);
                    fail_count++;
                end else begin
                    want = tok_exp.pop_front();
                    if (m_tdata[4:0] !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, m_tdata[4:0]);
                        fail_count++;
                    end
                    if (m_tdata[20:5] !== want.start) begin
                        $error("token_start: expected %0d, got %0d",
                               want.start, m_tdata[20:5]);
                        fail_count++;
                    end
                    if (m_tdata[36:21] !== want.length) begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, m_tdata[36:21]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("run_last: expected %0d, got %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("source_text_tokenizer: mismatch");
        $finish;
    end

endmodule
